@@ rtl/dfam_pkg.sv @@
// dfam_pkg: shared constants, item mode codes, register indexes and the
// stage record passed from the character map stage to the state walker.
// No dependencies; every other file of the matcher but dfam_ram imports it.
`default_nettype none

package dfam_pkg;

  // Automaton size
  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 16;

  // Fixed field widths
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int STATE_W = 4;
  localparam int SYM_W   = 4;

  // Character map: one entry per byte, valid flag over symbol
  localparam int MAP_DEPTH = 1 << CHAR_W;
  localparam int MAP_W     = SYM_W + 1;

  // Transition table: row per state, column per symbol
  localparam int TT_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int TT_AW    = $clog2(TT_DEPTH);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int MASK_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHAR  = 2'd0,
    MODE_END   = 2'd1,
    MODE_TRANS = 2'd2,
    MODE_MAP   = 2'd3
  } mode_t;

  typedef enum logic {
    REG_START_STATE = 1'b0,
    REG_ACCEPT_MASK = 1'b1
  } reg_idx_t;

  // Item held in the stage register, with its character map lookup
  typedef struct packed {
    mode_t              mode;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol_index;
    logic [STATE_W-1:0] next_state;
    logic               map_ok;
    logic [SYM_W-1:0]   map_sym;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/dfam_if.sv @@
// dfam_in_if / dfam_out_if: valid-ready channels for input items and
// verdicts. Depends on dfam_pkg for the field widths.
`default_nettype none

interface dfam_in_if
  import dfam_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   char_code;
  logic [STATE_W-1:0]  from_state;
  logic [SYM_W-1:0]    symbol_index;
  logic [STATE_W-1:0]  next_state;
  logic                map_valid;

  modport source (
    output valid, mode, char_code, from_state, symbol_index, next_state, map_valid,
    input  ready
  );
  modport sink (
    input  valid, mode, char_code, from_state, symbol_index, next_state, map_valid,
    output ready
  );
endinterface

interface dfam_out_if
  import dfam_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                accepted;
  logic                bad_char;
  logic [STATE_W-1:0]  final_state;

  modport source (
    output valid, accepted, bad_char, final_state,
    input  ready
  );
  modport sink (
    input  valid, accepted, bad_char, final_state,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/dfam_ram.sv @@
// dfam_ram: generic single-write, single-read memory with registered read
// data that holds while the read enable is low. No dependencies.
`default_nettype none

module dfam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dfam_char_map.sv @@
// dfam_char_map: input register stage. Accepts items, looks the byte up in
// the character map memory and presents the item with its map entry.
// Depends on dfam_pkg, dfam_if and dfam_ram.
`default_nettype none

module dfam_char_map
  import dfam_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dfam_in_if.sink    in_ch,
  output logic       stg_vld,
  output stage_t     stg,
  input  wire logic  stg_take
);

  logic                 accept;
  logic                 stg_vld_r;
  logic                 map_we;
  logic [MAP_W-1:0]     map_wdata;
  logic [MAP_W-1:0]     map_rdata;
  logic [MAP_DEPTH-1:0] written_r;
  logic                 written_hit_r;
  mode_t                mode_r;
  logic [STATE_W-1:0]   from_r;
  logic [SYM_W-1:0]     sym_r;
  logic [STATE_W-1:0]   next_r;
  logic [MAP_W-1:0]     entry;

  // Take a transaction when the stage is empty or being emptied
  assign in_ch.ready = !stg_vld_r || stg_take;
  assign accept      = in_ch.valid && in_ch.ready;

  assign map_we    = accept && (mode_t'(in_ch.mode) == MODE_MAP);
  assign map_wdata = {in_ch.map_valid, in_ch.symbol_index};

  dfam_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_ch.char_code),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (in_ch.char_code),
    .rdata (map_rdata)
  );

  // Per-byte written flags: an unwritten byte reads as invalid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (map_we) begin
      written_r[in_ch.char_code] <= 1'b1;
    end
  end

  // Stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (accept) begin
      stg_vld_r <= 1'b1;
    end else if (stg_take) begin
      stg_vld_r <= 1'b0;
    end
  end

  // Hold the item fields alongside the map read
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r        <= mode_t'(in_ch.mode);
      from_r        <= in_ch.from_state;
      sym_r         <= in_ch.symbol_index;
      next_r        <= in_ch.next_state;
      written_hit_r <= written_r[in_ch.char_code];
    end
  end

  assign entry = written_hit_r ? map_rdata : '0;

  always_comb begin
    stg.mode         = mode_r;
    stg.from_state   = from_r;
    stg.symbol_index = sym_r;
    stg.next_state   = next_r;
    stg.map_ok       = entry[MAP_W-1];
    stg.map_sym      = entry[SYM_W-1:0];
  end

  assign stg_vld = stg_vld_r;

endmodule

`default_nettype wire

@@ rtl/dfam_walker.sv @@
// dfam_walker: string state, transition table memory and the verdict
// register. Consumes staged items from dfam_char_map.
// Depends on dfam_pkg, dfam_if and dfam_ram.
`default_nettype none

module dfam_walker
  import dfam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               stg_vld,
  input  wire stage_t             stg,
  output logic                    stg_take,
  input  wire logic [STATE_W-1:0] start_state,
  input  wire logic [MASK_W-1:0]  accept_mask,
  dfam_out_if.source              out_ch
);

  logic               in_str_r, in_str_nxt;
  logic               err_r, err_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               pend_r, pend_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               acc_r;
  logic               bad_r;
  logic [STATE_W-1:0] fin_r;

  logic               out_free;
  logic [STATE_W-1:0] t_rdata;
  logic [STATE_W-1:0] state_eff;
  logic [STATE_W-1:0] base;
  logic               err_b;
  logic               sym_ok;
  logic               st_ok;
  logic               t_re;
  logic               t_we;
  logic [TT_AW-1:0]   t_raddr;
  logic [TT_AW-1:0]   t_waddr;
  logic               verdict;

  // A lookup issued last cycle supplies the live state
  assign state_eff = pend_r ? t_rdata : cur_r;

  // A string opens on its first item with the start state and no error
  assign base  = in_str_r ? state_eff : start_state;
  assign err_b = in_str_r && err_r;

  assign sym_ok = stg.map_ok && (32'(stg.map_sym) < NUM_SYMBOLS);
  assign st_ok  = 32'(base) < NUM_STATES;

  // Only a verdict waits for the output register
  assign out_free = !out_vld_r || out_ch.ready;
  assign stg_take = stg_vld && ((stg.mode != MODE_END) || out_free);

  // Transition table accesses
  assign t_re = stg_take && (stg.mode == MODE_CHAR) && !err_b && sym_ok && st_ok;
  assign t_we = stg_take && (stg.mode == MODE_TRANS) &&
                (32'(stg.from_state) < NUM_STATES) &&
                (32'(stg.symbol_index) < NUM_SYMBOLS);
  assign t_raddr = TT_AW'(TT_AW'(base) * TT_AW'(NUM_SYMBOLS) + TT_AW'(stg.map_sym));
  assign t_waddr = TT_AW'(TT_AW'(stg.from_state) * TT_AW'(NUM_SYMBOLS)
                          + TT_AW'(stg.symbol_index));

  dfam_ram #(
    .WIDTH (STATE_W),
    .DEPTH (TT_DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (stg.next_state),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign verdict = !err_b && accept_mask[base];

  // Next string state and verdict
  always_comb begin
    in_str_nxt  = in_str_r;
    err_nxt     = err_r;
    cur_nxt     = state_eff;
    pend_nxt    = 1'b0;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (stg_take) begin
      unique case (stg.mode)
        MODE_CHAR: begin
          in_str_nxt = 1'b1;
          err_nxt    = err_b || !sym_ok;
          cur_nxt    = base;
          pend_nxt   = t_re;
        end
        MODE_END: begin
          in_str_nxt  = 1'b0;
          err_nxt     = 1'b0;
          cur_nxt     = start_state;
          out_vld_nxt = 1'b1;
        end
        MODE_TRANS, MODE_MAP: begin
          cur_nxt = state_eff;
        end
        default: begin
          cur_nxt = state_eff;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_str_r  <= 1'b0;
      err_r     <= 1'b0;
      cur_r     <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_str_r  <= in_str_nxt;
      err_r     <= err_nxt;
      cur_r     <= cur_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Load the verdict transaction
  always_ff @(posedge clk) begin
    if (stg_take && (stg.mode == MODE_END)) begin
      acc_r <= verdict;
      bad_r <= err_b;
      fin_r <= base;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.accepted    = acc_r;
  assign out_ch.bad_char    = bad_r;
  assign out_ch.final_state = fin_r;

  // A pending lookup exists only inside a string
  a_pend_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> in_str_r)
    else $error("transition lookup pending outside a string");

  // The error flag lives only inside a string
  a_err_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> in_str_r)
    else $error("error flag set outside a string");

  // A lookup is issued only while no error is recorded
  a_pend_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !err_r)
    else $error("lookup issued after an invalid character");

  // A verdict closes the string and fills the output register
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_take && (stg.mode == MODE_END)) |=> (out_vld_r && !in_str_r && !err_r))
    else $error("verdict did not close the string");

endmodule

`default_nettype wire

@@ rtl/table_driven_dfa_matcher.sv @@
// table_driven_dfa_matcher: top level. Holds the configuration registers
// and joins the character map stage to the state walker.
// Depends on dfam_pkg, dfam_if, dfam_char_map and dfam_walker.
//
//   channel   direction  handshake         carries
//   in_ch     in         valid / ready     mode, char_code, from_state,
//                                          symbol_index, next_state, map_valid
//   out_ch    out        valid / ready     accepted, bad_char, final_state
//   cfg       in         APB, pready = 1   start_state @0x0, accept_mask @0x4
//
// One item per cycle while no verdict stalls the stage. An item sits in the
// stage register while the character map memory is read, then the transition
// table memory is read and its registered data is the next character's state,
// so characters run back to back. A verdict appears on out_ch the cycle after
// its end item leaves the stage. Only a verdict that finds the output register
// full stalls the stage, and so the input. Reset is synchronous; no clearing
// pass, the character map carries per-byte written flags.
`default_nettype none

module table_driven_dfa_matcher
  import dfam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  dfam_in_if.sink                in_ch,
  dfam_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic               stg_vld;
  stage_t             stg;
  logic               stg_take;
  logic [STATE_W-1:0] start_state_r;
  logic [MASK_W-1:0]  accept_mask_r;
  logic               cfg_wr;
  reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_START_STATE: start_state_r <= pwdata[STATE_W-1:0];
        REG_ACCEPT_MASK: accept_mask_r <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_START_STATE: prdata = CFG_DW'(start_state_r);
      REG_ACCEPT_MASK: prdata = CFG_DW'(accept_mask_r);
      default:         prdata = '0;
    endcase
  end

  dfam_char_map u_char_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .stg_vld  (stg_vld),
    .stg      (stg),
    .stg_take (stg_take)
  );

  dfam_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .stg_vld     (stg_vld),
    .stg         (stg),
    .stg_take    (stg_take),
    .start_state (start_state_r),
    .accept_mask (accept_mask_r),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

@@ test/tb_table_driven_dfa_matcher.sv @@
`timescale 1ns / 1ps
// Testbench for table_driven_dfa_matcher: drives map, table, character and end
// items with random gaps and checks every verdict against a DFA predictor.
// Depends on dfam_pkg, dfam_if and the matcher RTL.

module tb_table_driven_dfa_matcher;
  import dfam_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 8;

  typedef struct {
    mode_t              mode;
    logic [CHAR_W-1:0]  char_code;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol_index;
    logic [STATE_W-1:0] next_state;
    logic               map_valid;
  } dfa_item_t;

  typedef struct packed {
    logic               accepted;
    logic               bad_char;
    logic [STATE_W-1:0] final_state;
  } verdict_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  dfam_in_if  in_ch ();
  dfam_out_if out_ch ();

  table_driven_dfa_matcher dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted automaton state and tables
  logic [STATE_W-1:0] start_reg;
  logic [MASK_W-1:0]  mask_reg;
  logic [STATE_W-1:0] walk_state;
  bit                 walk_err;
  bit                 walk_open;
  logic [STATE_W-1:0] next_tab [NUM_STATES][NUM_SYMBOLS];
  bit                 tab_set  [NUM_STATES][NUM_SYMBOLS];
  logic [MAP_W-1:0]   byte_map [MAP_DEPTH];

  verdict_t verdict_q[$];
  int       fail_count;
  int       items_sent;
  bit       no_gaps;
  bit       hold_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Load the start state at the first item of a string
  function automatic void open_string();
    if (!walk_open) begin
      walk_state = start_reg;
      walk_err   = 1'b0;
      walk_open  = 1'b1;
    end
  endfunction

  // Advance the predicted automaton by one accepted item
  function automatic void predict_item(input dfa_item_t it);
    logic [MAP_W-1:0] ent;
    verdict_t         v;
    case (it.mode)
      MODE_CHAR: begin
        open_string();
        if (!walk_err) begin
          ent = byte_map[it.char_code];
          if (!ent[SYM_W]) walk_err = 1'b1;
          else walk_state = next_tab[walk_state][ent[SYM_W-1:0]];
        end
      end
      MODE_END: begin
        open_string();
        v.accepted    = !walk_err && mask_reg[walk_state];
        v.bad_char    = walk_err;
        v.final_state = walk_state;
        verdict_q.push_back(v);
        walk_open  = 1'b0;
        walk_err   = 1'b0;
        walk_state = start_reg;
      end
      MODE_TRANS: begin
        next_tab[it.from_state][it.symbol_index] = it.next_state;
        tab_set[it.from_state][it.symbol_index]  = 1'b1;
      end
      default: begin
        byte_map[it.char_code] = {it.map_valid, it.symbol_index};
      end
    endcase
  endfunction

  function automatic dfa_item_t rand_item(input mode_t m);
    dfa_item_t it;
    it.mode         = m;
    it.char_code    = CHAR_W'($urandom);
    it.from_state   = STATE_W'($urandom);
    it.symbol_index = SYM_W'($urandom);
    it.next_state   = STATE_W'($urandom);
    it.map_valid    = 1'($urandom);
    return it;
  endfunction

  function automatic dfa_item_t make_map(input logic [CHAR_W-1:0] code,
                                         input logic [SYM_W-1:0] sym, input logic ok);
    dfa_item_t it;
    it = rand_item(MODE_MAP);
    it.char_code    = code;
    it.symbol_index = sym;
    it.map_valid    = ok;
    return it;
  endfunction

  function automatic dfa_item_t make_trans(input logic [STATE_W-1:0] from,
                                           input logic [SYM_W-1:0] sym,
                                           input logic [STATE_W-1:0] nxt);
    dfa_item_t it;
    it = rand_item(MODE_TRANS);
    it.from_state   = from;
    it.symbol_index = sym;
    it.next_state   = nxt;
    return it;
  endfunction

  // Random byte from the current alphabet, or any byte if none is mapped
  function automatic logic [CHAR_W-1:0] pick_alphabet_byte();
    logic [CHAR_W-1:0] valid_bytes[$];
    for (int b = 0; b < MAP_DEPTH; b++)
      if (byte_map[b][SYM_W]) valid_bytes.push_back(CHAR_W'(b));
    if (valid_bytes.size() == 0) return CHAR_W'($urandom);
    return valid_bytes[$urandom_range(0, valid_bytes.size() - 1)];
  endfunction

  // Offer one item; hold valid until the transaction completes
  task automatic send_item(input dfa_item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= it.mode;
    in_ch.char_code    <= it.char_code;
    in_ch.from_state   <= it.from_state;
    in_ch.symbol_index <= it.symbol_index;
    in_ch.next_state   <= it.next_state;
    in_ch.map_valid    <= it.map_valid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  // Send a character, first writing the table entry it would read if unset
  task automatic feed_char(input logic [CHAR_W-1:0] code);
    logic [STATE_W-1:0] st;
    logic [MAP_W-1:0]   ent;
    dfa_item_t          it;
    st  = walk_open ? walk_state : start_reg;
    ent = byte_map[code];
    if (!(walk_open && walk_err) && ent[SYM_W] && !tab_set[st][ent[SYM_W-1:0]])
      send_item(make_trans(st, ent[SYM_W-1:0], STATE_W'($urandom)));
    it = rand_item(MODE_CHAR);
    it.char_code = code;
    send_item(it);
  endtask

  task automatic send_string(input int len, input int bad_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < bad_pct) feed_char(CHAR_W'($urandom));
      else feed_char(pick_alphabet_byte());
    end
    send_item(rand_item(MODE_END));
  endtask

  // Mostly well-formed strings, some table edits and some noise
  task automatic random_action(input int bad_pct);
    dfa_item_t   it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      send_string($urandom_range(0, 8), bad_pct);
    end else if (pick < 85) begin
      it = rand_item(MODE_MAP);
      it.map_valid = ($urandom_range(0, 3) != 0);
      send_item(it);
    end else if (pick < 92) begin
      send_item(rand_item(MODE_TRANS));
    end else begin
      it = rand_item(mode_t'($urandom_range(0, 3)));
      if (it.mode == MODE_CHAR) feed_char(it.char_code);
      else send_item(it);
    end
  endtask

  // Drop valid, wait for every verdict, then let the pipeline settle
  task automatic wait_verdicts_drained();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START_STATE: start_reg = value[STATE_W-1:0];
      default:         mask_reg  = value[MASK_W-1:0];
    endcase
  endtask

  task automatic write_settings(input logic [STATE_W-1:0] st, input logic [MASK_W-1:0] msk);
    logic [CFG_DW-1:0] val;
    val = $urandom;
    val[STATE_W-1:0] = st;
    write_reg(REG_START_STATE, val);
    val = $urandom;
    val[MASK_W-1:0] = msk;
    write_reg(REG_ACCEPT_MASK, val);
  endtask

  // Verdicts straight after reset: empty string and an unmapped byte
  task automatic test_reset_verdicts();
    send_item(rand_item(MODE_END));
    feed_char(8'h41);
    send_item(rand_item(MODE_END));
    wait_verdicts_drained();
  endtask

  // Hand-built walks over extreme bytes, states and symbols
  task automatic test_directed_walks();
    write_settings(4'd15, 16'h8001);
    send_item(make_map(8'h00, 4'd0, 1'b1));
    send_item(make_map(8'hFF, 4'd15, 1'b1));
    send_item(make_map(8'h80, 4'd7, 1'b0));
    send_item(make_trans(4'd15, 4'd0, 4'd0));
    send_item(make_trans(4'd0, 4'd15, 4'd15));
    send_item(make_trans(4'd15, 4'd15, 4'd15));
    send_item(make_trans(4'd0, 4'd0, 4'd15));
    // empty string judged on the start state
    send_item(rand_item(MODE_END));
    feed_char(8'h00);
    feed_char(8'hFF);
    send_item(rand_item(MODE_END));
    feed_char(8'h00);
    send_item(rand_item(MODE_END));
    // invalid byte freezes the state; later characters are ignored
    feed_char(8'h00);
    feed_char(8'h80);
    feed_char(8'hFF);
    send_item(rand_item(MODE_END));
    wait_verdicts_drained();
  endtask

  // Random traffic under extreme and random register settings
  task automatic test_register_settings();
    logic [STATE_W-1:0] st;
    logic [MASK_W-1:0]  msk;
    int                 goal;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0:       begin st = '0; msk = '0; end
        1:       begin st = '1; msk = '1; end
        2:       begin st = '0; msk = '1; end
        3:       begin st = '1; msk = '0; end
        default: begin st = STATE_W'($urandom); msk = MASK_W'($urandom); end
      endcase
      write_settings(st, msk);
      goal = items_sent + 60;
      while (items_sent < goal) random_action(10);
      wait_verdicts_drained();
    end
  endtask

  // Long random run, with a gap-free stretch and a mid-run pause
  task automatic test_random_strings();
    int goal;
    for (int chunk = 0; chunk < 5; chunk++) begin
      no_gaps = (chunk == 2);
      goal = items_sent + 90;
      while (items_sent < goal) random_action(6);
      if (chunk == 3) begin
        wait_verdicts_drained();
        write_settings(STATE_W'($urandom), MASK_W'($urandom));
      end
    end
    no_gaps = 1'b0;
    wait_verdicts_drained();
  endtask

  // Hold the receiver off while short strings pile up behind it
  task automatic test_output_backpressure();
    no_gaps  = 1'b1;
    hold_out = 1'b1;
    for (int i = 0; i < 30; i++) send_string($urandom_range(0, 2), 5);
    no_gaps = 1'b0;
    wait_verdicts_drained();
  endtask

  // Receiver: random stalls, then check each verdict transaction in order
  initial begin
    verdict_t want;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: accepted=%0b bad_char=%0b final_state=%0d",
               out_ch.accepted, out_ch.bad_char, out_ch.final_state);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_ch.accepted);
          fail_count++;
        end
        if (out_ch.bad_char !== want.bad_char) begin
          $error("bad_char: expected %0b, got %0b", want.bad_char, out_ch.bad_char);
          fail_count++;
        end
        if (out_ch.final_state !== want.final_state) begin
          $error("final_state: expected %0d, got %0d", want.final_state, out_ch.final_state);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Sequence the tests
  initial begin
    start_reg  = '0;
    mask_reg   = '0;
    walk_state = '0;
    walk_err   = 1'b0;
    walk_open  = 1'b0;
    fail_count = 0;
    items_sent = 0;
    no_gaps    = 1'b0;
    hold_out   = 1'b0;
    for (int s = 0; s < NUM_STATES; s++)
      for (int y = 0; y < NUM_SYMBOLS; y++) begin
        next_tab[s][y] = '0;
        tab_set[s][y]  = 1'b0;
      end
    for (int b = 0; b < MAP_DEPTH; b++) byte_map[b] = '0;

    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_CHAR;
    in_ch.char_code    <= '0;
    in_ch.from_state   <= '0;
    in_ch.symbol_index <= '0;
    in_ch.next_state   <= '0;
    in_ch.map_valid    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_verdicts();
    test_directed_walks();
    test_register_settings();
    test_random_strings();
    test_output_backpressure();

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
